// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the severity priority queue
// Record layout, request codes, cell control bundle and result bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default number of cells in the chain
  localparam int SPQ_CAPACITY = 16;

  // request codes carried on s_tuser
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // widths of the stream payloads
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int OCC_W      = 5;

  // one stored record, severity in the lowest bits
  typedef struct packed {
    logic [15:0] organ_tag;
    logic [15:0] name_tag;
    logic [6:0]  age;
    logic [7:0]  severity;
  } record_t;

  // command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
    logic clear;
  } cell_ctl_t;

  // one result waiting on the output side
  typedef struct packed {
    logic             ok;
    logic [OCC_W-1:0] occupancy;
    record_t          rec;
  } result_t;

endpackage

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one record; on insert it keeps, takes the new record or takes its
// left neighbor, on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  record_t   new_rec,
  input  record_t   left_rec,
  input  logic      left_valid,
  input  logic      left_keep,
  input  record_t   right_rec,
  input  logic      right_valid,
  output record_t   rec,
  output logic      valid,
  output logic      keep
);

  // a valid record of greater or equal severity stays in place
  assign keep = valid && (rec.severity >= new_rec.severity);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.remove) begin
      valid <= right_valid;
    end else if (ctl.insert) begin
      valid <= valid | left_valid;
    end
  end

  // record payload
  always_ff @(posedge clk) begin
    if (ctl.remove) begin
      rec <= right_rec;
    end else if (ctl.insert && !keep) begin
      rec <= left_keep ? new_rec : left_rec;
    end
  end

endmodule

// ===== hdl/spq_out_buf.sv =====
// ----------------------------------------------------------------------------
// spq_out_buf: result register with skid stage
// Lets a request be taken while a finished result still waits downstream.
// ----------------------------------------------------------------------------
module spq_out_buf
  import spq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid;
  logic    in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  // main register refills from skid first, else from the input
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payloads
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid : in_data;
    end else if (in_fire) begin
      skid <= in_data;
    end
  end

endmodule

// ===== hdl/severity_priority_queue.sv =====
// ----------------------------------------------------------------------------
// severity_priority_queue: bounded queue of records sorted by severity
// Top level: request decode, occupancy count, cell chain and result buffer.
// ----------------------------------------------------------------------------
// Records sit in a chain of CAPACITY cells, highest severity at cell 0, equal
// severities in arrival order. Every cell compares its own severity with an
// incoming record in the same cycle, so an insert, remove or clear updates
// every cell at once, and one request is taken every cycle while s_tready is
// high. The result is registered in the result register or, while that is
// full, in its skid stage, so one more request is taken while one waits;
// s_tready drops only when both are full. Clear drops all valid bits at once,
// and no clearing pass follows reset.
module severity_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // severity[7:0], age[14:8], name_tag[30:15], organ_tag[46:31], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_severity[7:0], out_age[14:8], out_name_tag[30:15],
  // out_organ_tag[46:31], occupancy[51:47], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // ok[0]
  output logic                  m_tuser
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  logic              full;
  logic              is_insert;
  logic              is_remove;
  logic              is_clear;
  logic              ok;
  record_t           new_rec;
  cell_ctl_t         ctl;
  result_t           res;
  result_t           res_q;
  record_t           cell_rec   [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_keep;

  assign accept  = s_tvalid && s_tready;
  assign new_rec = record_t'(s_tdata[$bits(record_t)-1:0]);
  assign full    = (count == CW'(CAPACITY));

  // request decode
  always_comb begin
    is_insert = 1'b0;
    is_remove = 1'b0;
    is_clear  = 1'b0;
    case (s_tuser)
      MODE_INSERT: is_insert = 1'b1;
      MODE_REMOVE: is_remove = 1'b1;
      MODE_CLEAR:  is_clear  = 1'b1;
      default:     ;
    endcase
  end

  // success and next occupancy
  always_comb begin
    ok         = 1'b0;
    count_next = count;
    if (is_insert && !full) begin
      ok         = 1'b1;
      count_next = count + 1'b1;
    end else if (is_remove && (count != '0)) begin
      ok         = 1'b1;
      count_next = count - 1'b1;
    end else if (is_clear && (count != '0)) begin
      ok         = 1'b1;
      count_next = '0;
    end
  end

  // broadcast command, only for requests that change the chain
  assign ctl.insert = accept && is_insert && ok;
  assign ctl.remove = accept && is_remove && ok;
  assign ctl.clear  = accept && is_clear && ok;

  // occupancy counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // chain of cells, cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    record_t left_rec;
    logic    left_valid;
    logic    left_keep;
    record_t right_rec;
    logic    right_valid;

    if (i == 0) begin : g_head
      assign left_rec   = new_rec;
      assign left_valid = 1'b1;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_rec   = cell_rec[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_rec   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_rec   = cell_rec[i+1];
      assign right_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_rec     (new_rec),
      .left_rec    (left_rec),
      .left_valid  (left_valid),
      .left_keep   (left_keep),
      .right_rec   (right_rec),
      .right_valid (right_valid),
      .rec         (cell_rec[i]),
      .valid       (cell_valid[i]),
      .keep        (cell_keep[i])
    );
  end

  // result of this request
  assign res.ok        = ok;
  assign res.occupancy = OCC_W'(count_next);
  assign res.rec       = (is_remove && ok) ? cell_rec[0] : '0;

  spq_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_data   (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_data  (res_q),
    .out_ready (m_tready)
  );

  // pack the master side
  assign m_tdata = {{(OUT_DATA_W - $bits(record_t) - OCC_W){1'b0}},
                    res_q.occupancy, res_q.rec};
  assign m_tuser = res_q.ok;

  // occupancy never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  // valid bits of the chain track the counter
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with occupancy");

  // valid cells form an unbroken run from the head
  a_valid_run: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid + 1'b1))
    else $error("gap in valid cells");

  // a successful insert grows the queue by one
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    accept && is_insert && !full |=> count == $past(count) + 1'b1)
    else $error("insert did not grow occupancy");

  // requests stall only while results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

// ===== tb/sv/tb_severity_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_severity_priority_queue: self-checking bench for the severity queue
// A directed table of requests runs first: empty-queue refusals, field
// extremes, severity ties, fill to capacity, overflow and clear. Random
// phases of insert-heavy, balanced and remove-heavy traffic follow. Source
// gaps and sink stalls come in random bursts. Each result is checked field by
// field against a sorted-queue model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_severity_priority_queue;
  import spq_pkg::*;

  localparam int QCAP = SPQ_CAPACITY;
  // request code with no operation behind it
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CALM_TAIL    = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [1:0] mode;
    record_t    rec;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [1:0]            s_tuser  = MODE_INSERT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // bench copy of the sorted queue, head at index 0
  record_t     held_recs[QCAP];
  int unsigned held_n = 0;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned refusals = 0;
  int unsigned removals = 0;
  int unsigned clears = 0;
  int unsigned peak_occ = 0;
  int unsigned src_gap_pct = 20;
  int unsigned sink_stall_pct = 20;
  int unsigned cycle_count = 0;

  severity_priority_queue #(
    .CAPACITY(QCAP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // apply one request to the bench queue and return the result it gives
  function automatic result_t queue_request(logic [1:0] mode, record_t rec);
    result_t     res;
    int unsigned pos;
    res = '0;
    case (mode)
      MODE_INSERT: begin
        if (held_n < QCAP) begin
          // stable order: go past every record of greater or equal severity
          pos = 0;
          while (pos < held_n && held_recs[pos].severity >= rec.severity) pos++;
          for (int unsigned i = held_n; i > pos; i--) held_recs[i] = held_recs[i-1];
          held_recs[pos] = rec;
          held_n++;
          res.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (held_n != 0) begin
          res.rec = held_recs[0];
          for (int unsigned i = 1; i < held_n; i++) held_recs[i-1] = held_recs[i];
          held_n--;
          res.ok = 1'b1;
        end
      end
      MODE_CLEAR: begin
        res.ok = (held_n != 0);
        held_n = 0;
      end
      default: ;
    endcase
    res.occupancy = held_n[OCC_W-1:0];
    return res;
  endfunction

  function automatic stim_row_t dir_row(logic [1:0] mode, logic [7:0] sev, logic [6:0] age,
                                        logic [15:0] name, logic [15:0] organ,
                                        bit typed = 1'b0, bit ok = 1'b0, int occ = 0);
    stim_row_t r;
    r.mode              = mode;
    r.rec.severity      = sev;
    r.rec.age           = age;
    r.rec.name_tag      = name;
    r.rec.organ_tag     = organ;
    r.typed             = typed;
    r.want              = '0;
    r.want.ok           = ok;
    r.want.occupancy    = occ[OCC_W-1:0];
    return r;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // drive one request, wait for acceptance, record what it should return
  task automatic issue_request(logic [1:0] mode, record_t rec, bit typed, result_t typed_res);
    result_t res;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{(IN_DATA_W-$bits(record_t)){1'b0}}, rec};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = queue_request(mode, rec);
    pending_results.push_back(typed ? typed_res : res);
    requests_sent++;
    if (!res.ok) refusals++;
    if (res.ok && mode == MODE_REMOVE) removals++;
    if (res.ok && mode == MODE_CLEAR) clears++;
    if (held_n > peak_occ) peak_occ = held_n;
    // random gap on the source side
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // sink pacing: stall bursts while enabled, otherwise always ready
  initial begin : sink_pacing
    forever begin
      @(posedge clk);
      if (!rst && sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ok        = m_tuser;
      got.rec       = m_tdata[$bits(record_t)-1:0];
      got.occupancy = m_tdata[$bits(record_t) +: OCC_W];
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with no request outstanding: ok=%0b occ=%0d sev=%0d",
                                got.ok, got.occupancy, got.rec.severity));
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.occupancy !== want.occupancy ||
            got.rec.severity !== want.rec.severity || got.rec.age !== want.rec.age ||
            got.rec.name_tag !== want.rec.name_tag ||
            got.rec.organ_tag !== want.rec.organ_tag)
          flag_mismatch({
            $sformatf("exp ok=%0b occ=%0d sev=%0d age=%0d name=%h organ=%h",
                      want.ok, want.occupancy, want.rec.severity, want.rec.age,
                      want.rec.name_tag, want.rec.organ_tag),
            $sformatf(" / got ok=%0b occ=%0d sev=%0d age=%0d name=%h organ=%h",
                      got.ok, got.occupancy, got.rec.severity, got.rec.age,
                      got.rec.name_tag, got.rec.organ_tag)});
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("severity_priority_queue verification failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_rows[$];
    logic [1:0]  mode;
    record_t     rec;
    int unsigned ins_pct;
    int unsigned phase_left;
    int unsigned counted;
    int unsigned pick;

    // directed table: refusals on empty, extremes, ties, fill, overflow, clear
    dir_rows = '{
      dir_row(MODE_REMOVE, 8'h00, 7'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 0),
      dir_row(MODE_CLEAR,  8'hff, 7'h7f, 16'hffff, 16'hffff, 1'b1, 1'b0, 0),
      dir_row(MODE_UNUSED, 8'hff, 7'h7f, 16'hffff, 16'hffff, 1'b1, 1'b0, 0),
      dir_row(MODE_INSERT, 8'hff, 7'h7f, 16'hffff, 16'hffff),
      dir_row(MODE_INSERT, 8'h00, 7'h00, 16'h0000, 16'h0000),
      dir_row(MODE_INSERT, 8'h80, 7'h01, 16'h0001, 16'h8000),
      dir_row(MODE_INSERT, 8'h80, 7'h02, 16'h0002, 16'h4000),
      dir_row(MODE_INSERT, 8'h80, 7'h03, 16'h0003, 16'h2000),
      dir_row(MODE_INSERT, 8'h00, 7'h55, 16'haaaa, 16'h5555),
      dir_row(MODE_INSERT, 8'hff, 7'h2a, 16'h5555, 16'haaaa),
      dir_row(MODE_REMOVE, 8'h00, 7'h00, 16'h0000, 16'h0000),
      dir_row(MODE_INSERT, 8'h40, 7'h10, 16'h1111, 16'h0f0f),
      dir_row(MODE_INSERT, 8'hc8, 7'h20, 16'h2222, 16'hf0f0),
      dir_row(MODE_INSERT, 8'h01, 7'h30, 16'h3333, 16'h00ff),
      dir_row(MODE_INSERT, 8'hfe, 7'h40, 16'h4444, 16'hff00),
      dir_row(MODE_INSERT, 8'h80, 7'h04, 16'h0004, 16'h1000),
      dir_row(MODE_INSERT, 8'h07, 7'h50, 16'h6666, 16'h1234),
      dir_row(MODE_INSERT, 8'h7f, 7'h60, 16'h7777, 16'h4321),
      dir_row(MODE_INSERT, 8'h81, 7'h70, 16'h8888, 16'hbeef),
      dir_row(MODE_INSERT, 8'h64, 7'h0f, 16'h9999, 16'hcafe),
      dir_row(MODE_INSERT, 8'h00, 7'h7e, 16'hfffe, 16'h0001),
      dir_row(MODE_INSERT, 8'h10, 7'h11, 16'h1234, 16'h5678, 1'b1, 1'b0, QCAP),
      dir_row(MODE_REMOVE, 8'h00, 7'h00, 16'h0000, 16'h0000),
      dir_row(MODE_CLEAR,  8'h00, 7'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, 0)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      issue_request(dir_rows[i].mode, dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].want);

    // random phases with varying insert/remove balance
    counted    = 0;
    phase_left = 0;
    ins_pct    = 50;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 120);
        case ($urandom_range(0, 2))
          0:       ins_pct = 20;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
        if ($urandom_range(0, 3) == 0) begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end else begin
          src_gap_pct    = $urandom_range(5, 30);
          sink_stall_pct = $urandom_range(5, 30);
        end
      end
      phase_left--;
      // no idling in the closing stretch
      if (RANDOM_ITEMS - counted <= CALM_TAIL) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 2)                         mode = MODE_CLEAR;
      else if (pick < 4)                    mode = MODE_UNUSED;
      else if (pick < 4 + ins_pct * 96 / 100) mode = MODE_INSERT;
      else                                  mode = MODE_REMOVE;

      // narrow severities most of the time so ties are common
      case ($urandom_range(0, 9))
        0:             rec.severity = 8'h00;
        1:             rec.severity = 8'hff;
        2, 3, 4, 5:    rec.severity = 8'($urandom_range(0, 7));
        default:       rec.severity = 8'($urandom_range(0, 255));
      endcase
      rec.age       = 7'($urandom_range(0, 127));
      rec.name_tag  = 16'($urandom_range(0, 65535));
      rec.organ_tag = 16'($urandom_range(0, 65535));

      issue_request(mode, rec, 1'b0, '0);
      if (mode != MODE_UNUSED) counted++;
    end
    s_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d results, %0d records removed, %0d refusals, %0d clears",
             requests_sent, results_seen, removals, refusals, clears);
    $display("queue depth peaked at %0d of %0d, %0d mismatches", peak_occ, QCAP, mismatches);
    if (mismatches == 0) begin
      $display("severity_priority_queue verification clean");
    end else begin
      $display("severity_priority_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/spq_out_buf.sv
hdl/severity_priority_queue.sv
tb/sv/tb_severity_priority_queue.sv
